[hdl/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package sem_pkg;

  localparam int PIX_W      = 24;  // packed RGB pixel, red in the low byte
  localparam int CH_W       = 8;
  localparam int FW_W       = 11;
  localparam int FH_W       = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int S_W        = 22;  // sum of squares, below 2^21 fits easily
  localparam int N_W        = 23;  // root accumulator incl. bit headroom
  localparam int ROOT_STEPS = 12;  // one result bit per step, 2^22 down to 2^0
  localparam int STEP_W     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  // Controller to datapath
  typedef struct packed {
    logic              load;    // capture the input transfer
    logic              update;  // line/window/counter update, line data valid
    logic              square;  // form gradients and sums of squares
    logic              root;    // one square root step
    logic [STEP_W-1:0] step;
  } sem_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic emit;  // current item produces a result
  } sem_sts_t;

  function automatic logic [CH_W-1:0] chan(input logic [PIX_W-1:0] px, input int k);
    return px[k*CH_W +: CH_W];
  endfunction

endpackage

[hdl/sem_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module sem_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[hdl/sem_ctrl.sv]
// Controller state machine: sequences read, update, square and root steps.
// Depends on sem_pkg.
`timescale 1ns / 1ps

module sem_ctrl
  import sem_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  sem_sts_t sts_i,
  output sem_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_UPDATE, ST_SQUARE, ST_ROOT, ST_OUT
  } state_e;

  state_e            state_q;
  logic [STEP_W-1:0] step_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE:   if (in_valid_i) state_q <= ST_READ;
        ST_READ:   state_q <= ST_UPDATE;
        ST_UPDATE: state_q <= sts_i.emit ? ST_SQUARE : ST_IDLE;
        ST_SQUARE: begin
          state_q <= ST_ROOT;
          step_q  <= '0;
        end
        ST_ROOT: begin
          if (step_q == STEP_W'(ROOT_STEPS - 1)) begin
            state_q <= ST_OUT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_OUT:    if (out_ready_i) state_q <= ST_IDLE;
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

  // Command decode
  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = (state_q == ST_OUT);
  assign cmd_o.load   = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.update = (state_q == ST_UPDATE);
  assign cmd_o.square = (state_q == ST_SQUARE);
  assign cmd_o.root   = (state_q == ST_ROOT);
  assign cmd_o.step   = step_q;

endmodule

[hdl/sem_dpath.sv]
// Datapath: config registers, line memory, 3x3 window, position counters,
// gradient/square stage and iterative rounded square root. Uses sem_pkg, sem_ram.
`timescale 1ns / 1ps

module sem_dpath
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sem_cmd_t              cmd_i,
  output sem_sts_t              sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  action_i,
  input  logic [CH_W-1:0]       in_red_i,
  input  logic [CH_W-1:0]       in_green_i,
  input  logic [CH_W-1:0]       in_blue_i,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o,
  output logic                  frame_end_o
);

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int WCL = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (WCL > FW_W) ? WCL : FW_W;

  // Configuration
  logic [FW_W-1:0] fw_q;
  logic [FH_W-1:0] fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_FRAME_WIDTH:  fw_q <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: fh_q <= cfg_data_i[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  // Clamped frame size
  logic [WW-1:0]   w_eff;
  logic [FH_W-1:0] h_eff;

  always_comb begin
    w_eff = WW'(fw_q);
    if (fw_q == '0) begin
      w_eff = WW'(1);
    end else if (WW'(fw_q) > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end
    h_eff = (fh_q == '0) ? FH_W'(1) : fh_q;
  end

  // Captured input transfer
  logic             act_q;
  logic [PIX_W-1:0] px_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      px_q  <= {in_blue_i, in_green_i, in_red_i};
    end
  end

  // Position state
  logic [FW_W-1:0]  col_q, col_d, drn_q, drn_d;
  logic [FH_W-1:0]  row_q, row_d;
  logic [PIX_W-1:0] win_q [9];
  logic [PIX_W-1:0] win_d [9];
  logic [PIX_W-1:0] emw_q [9];
  logic [PIX_W-1:0] emw_d [9];
  logic             last_q, last_d;

  logic             draining, final_tick, skip, in_mem, emit;
  logic [FW_W-1:0]  c_sel;
  logic [FH_W-1:0]  r_sel, row_inc;
  logic [31:0]      c_wide;
  logic [AW-1:0]    ram_addr;
  logic [2*PIX_W-1:0] ram_rd;
  logic [PIX_W-1:0] upper, middle, cur_px, col0, col1;
  logic             ram_we;

  assign draining   = (row_q >= h_eff);
  assign c_sel      = draining ? drn_q : col_q;
  assign r_sel      = draining ? h_eff : row_q;
  assign in_mem     = (WW'(c_sel) < WW'(MAX_WIDTH));
  assign final_tick = draining && (WW'(drn_q) >= w_eff);
  assign skip       = !draining && act_q;
  assign c_wide     = 32'(c_sel);
  assign ram_addr   = c_wide[AW-1:0];
  assign upper      = ram_rd[2*PIX_W-1:PIX_W];
  assign middle     = ram_rd[PIX_W-1:0];
  assign cur_px     = draining ? '0 : px_q;
  assign col0       = (in_mem && r_sel >= FH_W'(2)) ? upper : '0;
  assign col1       = (in_mem && r_sel >= FH_W'(1)) ? middle : '0;
  assign row_inc    = row_q + 1'b1;
  assign ram_we     = cmd_i.update && !skip && !final_tick && !draining && in_mem;

  sem_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_addr),
    .wdata_i({middle, px_q}),
    .raddr_i(ram_addr),
    .rdata_o(ram_rd)
  );

  // Window, counters and result window selection
  always_comb begin
    win_d  = win_q;
    emw_d  = emw_q;
    col_d  = col_q;
    row_d  = row_q;
    drn_d  = drn_q;
    last_d = 1'b0;
    emit   = 1'b0;
    if (skip) begin
      emit = 1'b0;
    end else if (final_tick) begin
      for (int r = 0; r < 3; r++) begin
        emw_d[r*3]     = win_q[r*3+1];
        emw_d[r*3+1]   = win_q[r*3+2];
        emw_d[r*3+2]   = '0;
        win_d[r*3]     = '0;
        win_d[r*3+1]   = '0;
        win_d[r*3+2]   = '0;
      end
      emit   = 1'b1;
      last_d = 1'b1;
      col_d  = '0;
      row_d  = '0;
      drn_d  = '0;
    end else begin
      if (c_sel == '0) begin
        for (int r = 0; r < 3; r++) begin
          emw_d[r*3]   = win_q[r*3+1];
          emw_d[r*3+1] = win_q[r*3+2];
          emw_d[r*3+2] = '0;
          win_d[r*3]   = '0;
          win_d[r*3+1] = '0;
        end
        emit = (r_sel >= FH_W'(2));
      end else begin
        for (int r = 0; r < 3; r++) begin
          win_d[r*3]   = win_q[r*3+1];
          win_d[r*3+1] = win_q[r*3+2];
        end
        emit = (r_sel >= FH_W'(1));
      end
      win_d[2] = col0;
      win_d[5] = col1;
      win_d[8] = cur_px;
      if (c_sel != '0) begin
        emw_d = win_d;
      end
      if (draining) begin
        drn_d = drn_q + 1'b1;
      end else if ({1'b0, WW'(c_sel)} + 1'b1 >= {1'b0, w_eff}) begin
        col_d = '0;
        row_d = row_inc;
        if (row_inc >= h_eff) begin
          drn_d = '0;
        end
      end else begin
        col_d = c_sel + 1'b1;
      end
    end
  end

  assign sts_o.emit = emit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      drn_q <= '0;
      for (int i = 0; i < 9; i++) begin
        win_q[i] <= '0;
      end
    end else if (cmd_i.update) begin
      col_q <= col_d;
      row_q <= row_d;
      drn_q <= drn_d;
      win_q <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      emw_q  <= emw_d;
      last_q <= last_d;
    end
  end

  // Gradients, squares and the shift-subtract square root, per channel
  logic [N_W-1:0] x_q [3];
  logic [N_W-1:0] n_q [3];
  logic [N_W-1:0] x_d [3];
  logic [N_W-1:0] n_d [3];
  logic [N_W-1:0] root_bit;
  logic [CH_W-1:0] res [3];

  assign root_bit = N_W'(1) << (5'd22 - {cmd_i.step, 1'b0});

  always_comb begin
    logic signed [11:0] gx, gy;
    logic [21:0]        sx, sy;
    logic [N_W-1:0]     trial, nr;
    x_d = x_q;
    n_d = n_q;
    for (int k = 0; k < 3; k++) begin
      gx = (12'(chan(emw_q[2], k)) + {3'b0, chan(emw_q[5], k), 1'b0} + 12'(chan(emw_q[8], k)))
         - (12'(chan(emw_q[0], k)) + {3'b0, chan(emw_q[3], k), 1'b0} + 12'(chan(emw_q[6], k)));
      gy = (12'(chan(emw_q[6], k)) + {3'b0, chan(emw_q[7], k), 1'b0} + 12'(chan(emw_q[8], k)))
         - (12'(chan(emw_q[0], k)) + {3'b0, chan(emw_q[1], k), 1'b0} + 12'(chan(emw_q[2], k)));
      sx = 22'(gx * gx);
      sy = 22'(gy * gy);
      trial = n_q[k] + root_bit;
      if (cmd_i.square) begin
        x_d[k] = N_W'(sx) + N_W'(sy);
        n_d[k] = '0;
      end else if (cmd_i.root) begin
        if (x_q[k] >= trial) begin
          x_d[k] = x_q[k] - trial;
          n_d[k] = (n_q[k] >> 1) + root_bit;
        end else begin
          n_d[k] = n_q[k] >> 1;
        end
      end
      // Round up when the remainder exceeds the root, then saturate
      nr = n_q[k] + N_W'(x_q[k] > n_q[k]);
      res[k] = (nr > N_W'(255)) ? 8'hFF : nr[CH_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.square || cmd_i.root) begin
      x_q <= x_d;
      n_q <= n_d;
    end
  end

  assign out_red_o   = res[0];
  assign out_green_o = res[1];
  assign out_blue_o  = res[2];
  assign frame_end_o = last_q;

endmodule

[hdl/sobel_edge_magnitude_rgb.sv]
// Streaming 3x3 Sobel edge magnitude on RGB pixels, one item at a time.
// Input transfer to result: line read, update, square, then 12 root steps.
// Items that give no result go through line read and update only; input is accepted again the cycle after.
// The shared iterative square root holds the block: a new item is accepted only after the last result is taken.
// Reset (rst_ni low, async) clears window, counters and sets 640x480; line
// memory is not cleared, rows above the frame are masked.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  action_i,
  input  logic [CH_W-1:0]       in_red_i,
  input  logic [CH_W-1:0]       in_green_i,
  input  logic [CH_W-1:0]       in_blue_i,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       out_red_o,
  output logic [CH_W-1:0]       out_green_o,
  output logic [CH_W-1:0]       out_blue_o,
  output logic                  frame_end_o
);

  sem_cmd_t cmd;
  sem_sts_t sts;

  sem_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sem_dpath #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .action_i   (action_i),
    .in_red_i   (in_red_i),
    .in_green_i (in_green_i),
    .in_blue_i  (in_blue_i),
    .out_red_o  (out_red_o),
    .out_green_o(out_green_o),
    .out_blue_o (out_blue_o),
    .frame_end_o(frame_end_o)
  );

`ifndef NO_ASSERTIONS
  // Only one item in flight: no input while a result is pending
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input ready while result pending");

  // An input transfer always starts processing
  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after transfer");

  // A result transfer frees the block
  a_free_after_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && out_ready) |=> (in_ready && !out_valid))
    else $error("not idle after result transfer");
`endif

endmodule

[verif/sobel_edge_magnitude_rgb_tb.sv]
// Self-checking testbench for sobel_edge_magnitude_rgb: streams RGB frames and compares
// every result against an in-bench Sobel magnitude predictor. Depends on sem_pkg and the RTL.
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_tb;
  import sem_pkg::*;

  localparam int LINE_DEPTH  = 1024;
  localparam int STALL_LIMIT = 3000;
  localparam int SETTLE_CYC  = 24;

  typedef enum logic {ACT_PIXEL = 1'b0, ACT_DRAIN = 1'b1} action_e;
  typedef enum int {FILL_RANDOM, FILL_BLACK, FILL_WHITE, FILL_CHECKER, FILL_EXTREME}
    fill_e;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } grad_px_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid;
  logic                  in_ready;
  logic                  action_i;
  logic [CH_W-1:0]       in_red_i, in_green_i, in_blue_i;
  logic                  out_valid;
  logic                  out_ready;
  logic [CH_W-1:0]       out_red_o, out_green_o, out_blue_o;
  logic                  frame_end_o;

  sobel_edge_magnitude_rgb dut (.*);

  // Predictor state
  logic [PIX_W-1:0] upper_mem [LINE_DEPTH];
  logic [PIX_W-1:0] middle_mem[LINE_DEPTH];
  logic [PIX_W-1:0] win[9];
  int unsigned      col_pos, row_pos, drain_pos;
  logic [FW_W-1:0]  width_reg;
  logic [FH_W-1:0]  height_reg;

  grad_px_t expected_px[$];
  int       errors;
  int       burst_left;
  int       idle_cycles;
  int       sent_items;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic [CH_W-1:0] rounded_mag(int gx, int gy);
    int unsigned s, n;
    s = gx * gx + gy * gy;
    n = 0;
    for (int b = 11; b >= 0; b--) begin
      if ((n | (1 << b)) * (n | (1 << b)) <= s) n = n | (1 << b);
    end
    if (s - n * n > n) n++;
    return (n > 255) ? 8'd255 : n[7:0];
  endfunction

  // Gradient magnitude of a 3x3 window (row major), queued as the next expected result
  function automatic void push_gradient(input logic [PIX_W-1:0] t[9], input bit last);
    grad_px_t   g;
    int         gx, gy;
    logic [7:0] m[3];
    for (int k = 0; k < 3; k++) begin
      gx = (int'(t[2][k*8+:8]) + 2 * int'(t[5][k*8+:8]) + int'(t[8][k*8+:8]))
         - (int'(t[0][k*8+:8]) + 2 * int'(t[3][k*8+:8]) + int'(t[6][k*8+:8]));
      gy = (int'(t[6][k*8+:8]) + 2 * int'(t[7][k*8+:8]) + int'(t[8][k*8+:8]))
         - (int'(t[0][k*8+:8]) + 2 * int'(t[1][k*8+:8]) + int'(t[2][k*8+:8]));
      m[k] = rounded_mag(gx, gy);
    end
    g.red = m[0]; g.green = m[1]; g.blue = m[2]; g.last = last;
    expected_px.push_back(g);
  endfunction

  function automatic void shifted_window(output logic [PIX_W-1:0] t[9]);
    for (int r = 0; r < 3; r++) begin
      t[r*3]   = win[r*3+1];
      t[r*3+1] = win[r*3+2];
      t[r*3+2] = '0;
    end
  endfunction

  function automatic void predict_transfer(input logic act, input logic [PIX_W-1:0] px_in);
    int unsigned      w, h, r, c;
    logic [PIX_W-1:0] px, col[3], t[9];
    bit               draining;
    w = width_reg;
    h = height_reg;
    if (w < 1) w = 1;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    if (h < 1) h = 1;
    draining = row_pos >= h;
    if (!draining && act == ACT_DRAIN) return;
    if (draining && drain_pos >= w) begin
      // final drain tick closes the last pixel of the frame
      shifted_window(t);
      push_gradient(t, 1'b1);
      foreach (win[i]) win[i] = '0;
      col_pos = 0; row_pos = 0; drain_pos = 0;
      return;
    end
    if (draining) begin
      r = h; c = drain_pos; px = '0;
    end else begin
      r = row_pos; c = col_pos; px = px_in;
    end
    col[0] = (r >= 2) ? upper_mem[c] : '0;
    col[1] = (r >= 1) ? middle_mem[c] : '0;
    col[2] = px;
    if (c == 0) begin
      shifted_window(t);
      if (r >= 2) push_gradient(t, 1'b0);
      for (int k = 0; k < 3; k++) begin
        win[k*3] = '0; win[k*3+1] = '0; win[k*3+2] = col[k];
      end
    end else begin
      for (int k = 0; k < 3; k++) begin
        win[k*3] = win[k*3+1]; win[k*3+1] = win[k*3+2]; win[k*3+2] = col[k];
      end
      if (r >= 1) push_gradient(win, 1'b0);
    end
    if (draining) begin
      drain_pos = (drain_pos + 1) & 11'h7FF;
    end else begin
      upper_mem[c]  = middle_mem[c];
      middle_mem[c] = px;
      if (c + 1 >= w) begin
        col_pos = 0;
        row_pos = (row_pos + 1) & 12'hFFF;
        if (row_pos >= h) drain_pos = 0;
      end else begin
        col_pos = c + 1;
      end
    end
  endfunction

  // One input transfer; sender idles in bursts. Called and returns on a rising edge.
  task automatic send_item(input logic act, input logic [7:0] r, g, b);
    int gap;
    bit hs;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid   <= 1'b1;
    action_i   <= act;
    in_red_i   <= r;
    in_green_i <= g;
    in_blue_i  <= b;
    do begin
      @(negedge clk_i);
      hs = in_ready;
      @(posedge clk_i);
    end while (!hs);
    predict_transfer(act, {b, g, r});
    sent_items++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    burst_left = 0;
  endtask

  // Register write, only with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    idle_input();
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val[CFG_DATA_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_FRAME_WIDTH) width_reg = val[FW_W-1:0];
    else height_reg = val[FH_W-1:0];
  endtask

  function automatic logic [PIX_W-1:0] fill_px(fill_e f, int unsigned x, int unsigned y);
    case (f)
      FILL_BLACK:   return '0;
      FILL_WHITE:   return '1;
      FILL_CHECKER: return ((x + y) % 2) ? '1 : '0;
      FILL_EXTREME: return {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom),
                            $urandom_range(0, 1) ? 8'hFF : 8'h00};
      default:      return PIX_W'($urandom);
    endcase
  endfunction

  // Whole frame plus its drain; noise adds ignored drain ticks and pixels in the drain
  task automatic run_frame(input int unsigned w, h, input fill_e f, input int noise_pct);
    int unsigned      we, he;
    logic [PIX_W-1:0] px;
    write_reg(REG_FRAME_WIDTH, w);
    write_reg(REG_FRAME_HEIGHT, h);
    we = (w < 1) ? 1 : (w > LINE_DEPTH) ? LINE_DEPTH : w;
    he = (h < 1) ? 1 : h;
    for (int unsigned y = 0; y < he; y++) begin
      for (int unsigned x = 0; x < we; x++) begin
        if ($urandom_range(0, 99) < noise_pct)
          send_item(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom));
        px = fill_px(f, x, y);
        send_item(ACT_PIXEL, px[7:0], px[15:8], px[23:16]);
      end
    end
    for (int unsigned d = 0; d <= we; d++) begin
      px = PIX_W'($urandom);
      if ($urandom_range(0, 99) < noise_pct) send_item(ACT_PIXEL, px[7:0], px[15:8], px[23:16]);
      else send_item(ACT_DRAIN, px[7:0], px[15:8], px[23:16]);
    end
  endtask

  task automatic test_ignored_drain_after_reset();
    for (int i = 0; i < 3; i++) send_item(ACT_DRAIN, 8'hFF, 8'h00, 8'hA5);
  endtask

  task automatic test_directed_corners();
    run_frame(3, 3, FILL_CHECKER, 0);
    run_frame(1, 1, FILL_WHITE, 0);
    run_frame(2, 2, FILL_WHITE, 0);
    run_frame(0, 0, FILL_EXTREME, 0);   // zero width and height count as one
  endtask

  task automatic test_drain_noise();
    run_frame(4, 3, FILL_RANDOM, 40);
  endtask

  task automatic test_size_extremes();
    run_frame(40, 1, FILL_EXTREME, 0);  // single wide row
    run_frame(1, 40, FILL_RANDOM, 0);   // single tall column
  endtask

  task automatic test_random_frames();
    int start;
    fill_e f;
    start = sent_items;
    while (sent_items - start < 320) begin
      f = fill_e'($urandom_range(0, 4));
      if ($urandom_range(0, 4) == 0) f = FILL_RANDOM;
      run_frame($urandom_range(1, 12), $urandom_range(1, 8), f,
                ($urandom_range(0, 2) == 0) ? 15 : 0);
    end
  endtask

  // Receiver stall pattern: phases of always ready, random, and mostly stalled
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      case ((idle_cycles + sent_items / 40) % 3)
        0:       out_ready <= 1'b1;
        1:       out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Result check and watchdog, sampled mid-cycle ahead of the transfer edge
  always @(negedge clk_i) begin
    grad_px_t e;
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (expected_px.size() == 0) begin
          $display("%0t: unexpected result r=%0d g=%0d b=%0d end=%0b", $time,
                   out_red_o, out_green_o, out_blue_o, frame_end_o);
          errors++;
        end else begin
          e = expected_px.pop_front();
          if (out_red_o !== e.red || out_green_o !== e.green || out_blue_o !== e.blue ||
              frame_end_o !== e.last) begin
            $display("%0t: expected r=%0d g=%0d b=%0d end=%0b, actual r=%0d g=%0d b=%0d end=%0b",
                     $time, e.red, e.green, e.blue, e.last,
                     out_red_o, out_green_o, out_blue_o, frame_end_o);
            errors++;
          end
        end
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid = 1'b0; action_i = 1'b0;
    in_red_i = '0; in_green_i = '0; in_blue_i = '0;
    errors = 0; burst_left = 0; idle_cycles = 0; sent_items = 0;
    foreach (win[i]) win[i] = '0;
    foreach (upper_mem[i]) begin
      upper_mem[i] = '0;
      middle_mem[i] = '0;
    end
    col_pos = 0; row_pos = 0; drain_pos = 0;
    width_reg = FRAME_WIDTH_RST;
    height_reg = FRAME_HEIGHT_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_ignored_drain_after_reset();
    test_directed_corners();
    test_drain_noise();
    test_size_extremes();
    test_random_frames();

    idle_input();
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
